/* rtl/ubq_pkg.sv */
package ubq_pkg;

   localparam int unsigned KindWidth = 3;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned RspWidth  = 48;

   localparam logic [ByteWidth-1:0] CrByte   = 8'h0D;
   localparam logic [ByteWidth-1:0] LineMax  = 8'hFF;

   typedef enum logic [KindWidth-1:0] {
      KIND_RX       = 3'd0,
      KIND_TX_READY = 3'd1,
      KIND_PUT      = 3'd2,
      KIND_GET      = 3'd3,
      KIND_LINE_ACK = 3'd4
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_stat_type;

endpackage

/* rtl/uart_buffered_rx_tx_queues.sv */
// Buffered serial port engine with a receive ring and a transmit ring.
// Input channel req_*: one event per item. req_tuser carries the event kind
// (receive, transmitter ready, put, get, line acknowledge), req_tdata the
// byte. Result channel rsp_*: exactly one item per event, carrying the byte
// sent to the transmitter, the byte read by software, and the status after
// the event (tx busy, ring levels, pending lines, sticky overflow).
// An accepted event is handled in a response state: the ring read is registered,
// then the result is registered into the output register and rsp_tvalid rises;
// no new event is accepted until the block is back in the idle state.
// Each ring is one BUF_DEPTH x 8 synchronous memory with separate read and write ports.
// Reset clears pointers, levels, line count, overflow and the transmit-on
// flag; ring contents are not cleared and need no clearing pass.
// When the receiver stalls, the result holds in the output register and no
// new event is accepted until it is taken; a result taken in the same cycle
// lets the next event in at once.
module uart_buffered_rx_tx_queues #(
   parameter int unsigned BUF_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] tx_valid, [8:1] tx_byte, [9] read_valid, [17:10] read_byte,
   // [18] tx_busy, [26:19] rx_level, [34:27] tx_level,
   // [42:35] lines_pending, [43] overflow, [47:44] zero
   output logic [47:0] rsp_tdata
);
   import ubq_pkg::*;

   localparam int unsigned FillWidth = $clog2(BUF_DEPTH + 1);

   state_type            state_ff, state_in;
   logic                 tx_on_ff, tx_on_in;
   logic [ByteWidth-1:0] line_cnt_ff, line_cnt_in;
   logic                 ovf_ff, ovf_in;
   logic                 pend_txv_ff, pend_txv_in;
   logic                 pend_from_mem_ff, pend_from_mem_in;
   logic                 pend_rdv_ff, pend_rdv_in;
   logic [ByteWidth-1:0] pend_byte_ff, pend_byte_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspWidth-1:0]  rsp_data_ff, rsp_data_in;

   ring_ctl_type         rx_ctl, tx_ctl;
   ring_stat_type        rx_stat, tx_stat;
   logic [ByteWidth-1:0] rx_rdata, tx_rdata;
   logic [FillWidth-1:0] rx_fill, tx_fill;
   logic                 req_fire;
   kind_type             kind;
   logic [ByteWidth-1:0] data_byte;
   logic [ByteWidth-1:0] tx_byte, read_byte;

   ubq_ring #(.DEPTH(BUF_DEPTH)) u_rx_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (rx_ctl),
      .wdata (data_byte),
      .rdata (rx_rdata),
      .fill  (rx_fill),
      .stat  (rx_stat)
   );

   ubq_ring #(.DEPTH(BUF_DEPTH)) u_tx_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (tx_ctl),
      .wdata (data_byte),
      .rdata (tx_rdata),
      .fill  (tx_fill),
      .stat  (tx_stat)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign data_byte  = req_tdata;

   assign tx_byte   = pend_txv_ff ? (pend_from_mem_ff ? tx_rdata : pend_byte_ff) : '0;
   assign read_byte = pend_rdv_ff ? rx_rdata : '0;

   always_comb begin
      state_in         = state_ff;
      tx_on_in         = tx_on_ff;
      line_cnt_in      = line_cnt_ff;
      ovf_in           = ovf_ff;
      pend_txv_in      = pend_txv_ff;
      pend_from_mem_in = pend_from_mem_ff;
      pend_rdv_in      = pend_rdv_ff;
      pend_byte_in     = pend_byte_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rx_ctl           = '0;
      tx_ctl           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pend_txv_in      = 1'b0;
               pend_from_mem_in = 1'b0;
               pend_rdv_in      = 1'b0;
               pend_byte_in     = data_byte;
               state_in         = ST_RESP;
               unique case (kind)
                  KIND_RX: begin
                     if (rx_stat.full) begin
                        ovf_in = 1'b1;
                     end else begin
                        rx_ctl.push = 1'b1;
                        if (data_byte == CrByte && line_cnt_ff != LineMax) begin
                           line_cnt_in = line_cnt_ff + 1'b1;
                        end
                     end
                  end
                  KIND_TX_READY: begin
                     if (tx_stat.empty) begin
                        tx_on_in = 1'b0;
                     end else begin
                        tx_ctl.pop       = 1'b1;
                        pend_txv_in      = 1'b1;
                        pend_from_mem_in = 1'b1;
                     end
                  end
                  KIND_PUT: begin
                     if (tx_on_ff) begin
                        if (tx_stat.full) begin
                           ovf_in = 1'b1;
                        end else begin
                           tx_ctl.push = 1'b1;
                        end
                     end else begin
                        // idle transmitter: send straight through
                        pend_txv_in = 1'b1;
                        tx_on_in    = 1'b1;
                     end
                  end
                  KIND_GET: begin
                     if (!rx_stat.empty) begin
                        rx_ctl.pop  = 1'b1;
                        pend_rdv_in = 1'b1;
                     end
                  end
                  KIND_LINE_ACK: begin
                     line_cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RESP: begin
            // ring read data is valid now; status registers already updated
            rsp_valid_in = 1'b1;
            rsp_data_in  = {4'b0000,
                            ovf_ff,
                            line_cnt_ff,
                            ByteWidth'(tx_fill),
                            ByteWidth'(rx_fill),
                            tx_on_ff,
                            read_byte,
                            pend_rdv_ff,
                            tx_byte,
                            pend_txv_ff};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tx_on_ff     <= 1'b0;
         line_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tx_on_ff     <= tx_on_in;
         line_cnt_ff  <= line_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_txv_ff      <= pend_txv_in;
      pend_from_mem_ff <= pend_from_mem_in;
      pend_rdv_ff      <= pend_rdv_in;
      pend_byte_ff     <= pend_byte_in;
      rsp_data_ff      <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/ubq_ring.sv */
module ubq_ring #(
   parameter int unsigned DEPTH = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ubq_pkg::ring_ctl_type        ctl,
   input  logic [7:0]                   wdata,
   output logic [7:0]                   rdata,
   output logic [$clog2(DEPTH+1)-1:0]   fill,
   output ubq_pkg::ring_stat_type       stat
);
   import ubq_pkg::*;

   localparam int unsigned PtrWidth  = $clog2(DEPTH);
   localparam int unsigned FillWidth = $clog2(DEPTH + 1);

   logic [ByteWidth-1:0] mem_ff [DEPTH];
   logic [ByteWidth-1:0] rdata_ff;
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0] fill_ff, fill_in;

   // wrap at the last entry, depth need not be a power of two
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
      if (ctl.pop) begin
         rdata_ff <= mem_ff[rd_ptr_ff];
      end
   end

   assign rdata      = rdata_ff;
   assign fill       = fill_ff;
   assign stat.full  = (fill_ff == FillWidth'(DEPTH));
   assign stat.empty = (fill_ff == '0);

endmodule

/* test/uart_buffered_rx_tx_queues_test.sv */
module uart_buffered_rx_tx_queues_test;

   import ubq_pkg::*;

   localparam int Depth        = 128;
   localparam int CycleLimit   = 200000;
   localparam int HoldCycles   = 80;
   localparam int SettleCycles = 10;
   localparam int IdlePercent  = 28;

   // kinds that the block ignores
   localparam logic [KindWidth-1:0] KindUnusedLo  = 3'd5;
   localparam logic [KindWidth-1:0] KindUnusedMid = 3'd6;
   localparam logic [KindWidth-1:0] KindUnusedHi  = 3'd7;

   typedef struct packed {
      logic [3:0]           pad;
      logic                 overflow;
      logic [ByteWidth-1:0] lines_pending;
      logic [ByteWidth-1:0] tx_level;
      logic [ByteWidth-1:0] rx_level;
      logic                 tx_busy;
      logic [ByteWidth-1:0] read_byte;
      logic                 read_valid;
      logic [ByteWidth-1:0] tx_byte;
      logic                 tx_valid;
   } status_word_type;

   class uart_ring_scoreboard;
      logic [ByteWidth-1:0] rx_ring [Depth];
      logic [ByteWidth-1:0] tx_ring [Depth];
      int unsigned          rx_head, rx_tail, rx_count;
      int unsigned          tx_head, tx_tail, tx_count;
      logic                 sending;
      logic [ByteWidth-1:0] line_count;
      logic                 dropped;
      status_word_type      expected_status[$];
      int                   mismatch_count;

      function new();
         rx_head = 0; rx_tail = 0; rx_count = 0;
         tx_head = 0; tx_tail = 0; tx_count = 0;
         sending = 1'b0;
         line_count = '0;
         dropped = 1'b0;
         mismatch_count = 0;
      endfunction

      function int unsigned advance(int unsigned ptr);
         return (ptr + 1 >= Depth) ? 0 : ptr + 1;
      endfunction

      function void note_event(logic [KindWidth-1:0] kind, logic [ByteWidth-1:0] data);
         status_word_type want;
         want = '0;
         case (kind)
            KIND_RX: begin
               if (rx_count >= Depth) begin
                  dropped = 1'b1;
               end else begin
                  rx_ring[rx_head] = data;
                  rx_head = advance(rx_head);
                  rx_count++;
                  if (data == CrByte && line_count != LineMax) line_count++;
               end
            end
            KIND_TX_READY: begin
               if (tx_count == 0) begin
                  sending = 1'b0;
               end else begin
                  want.tx_valid = 1'b1;
                  want.tx_byte = tx_ring[tx_tail];
                  tx_tail = advance(tx_tail);
                  tx_count--;
               end
            end
            KIND_PUT: begin
               if (sending) begin
                  if (tx_count >= Depth) begin
                     dropped = 1'b1;
                  end else begin
                     tx_ring[tx_head] = data;
                     tx_head = advance(tx_head);
                     tx_count++;
                  end
               end else begin
                  want.tx_valid = 1'b1;
                  want.tx_byte = data;
                  sending = 1'b1;
               end
            end
            KIND_GET: begin
               if (rx_count > 0) begin
                  want.read_valid = 1'b1;
                  want.read_byte = rx_ring[rx_tail];
                  rx_tail = advance(rx_tail);
                  rx_count--;
               end
            end
            KIND_LINE_ACK: line_count = '0;
            default: ;
         endcase
         want.tx_busy = sending;
         want.rx_level = rx_count[ByteWidth-1:0];
         want.tx_level = tx_count[ByteWidth-1:0];
         want.lines_pending = line_count;
         want.overflow = dropped;
         expected_status.push_back(want);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
         mismatch_count++;
      endtask

      task check_field(string what, int got, int want);
         if (got != want) report_mismatch(what, got, want);
      endtask

      task check_status(status_word_type got);
         status_word_type want;
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected result item", 1, 0);
            return;
         end
         want = expected_status.pop_front();
         check_field("tx_valid", got.tx_valid, want.tx_valid);
         check_field("tx_byte", got.tx_byte, want.tx_byte);
         check_field("read_valid", got.read_valid, want.read_valid);
         check_field("read_byte", got.read_byte, want.read_byte);
         check_field("tx_busy", got.tx_busy, want.tx_busy);
         check_field("rx_level", got.rx_level, want.rx_level);
         check_field("tx_level", got.tx_level, want.tx_level);
         check_field("lines_pending", got.lines_pending, want.lines_pending);
         check_field("overflow", got.overflow, want.overflow);
         check_field("pad", got.pad, want.pad);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ByteWidth-1:0] req_tdata = '0;
   logic [KindWidth-1:0] req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspWidth-1:0]  rsp_tdata;

   uart_ring_scoreboard ring_board = new();

   logic quiet = 1'b0;        // no idling on either side while set
   int   hold_epoch = 0;      // bump to make the receiver hold off
   int   seen_epoch = 0;
   int   hold_left = 0;
   int   cycle_count = 0;

   uart_buffered_rx_tx_queues #(.BUF_DEPTH(Depth)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_epoch != seen_epoch) begin
         seen_epoch <= hold_epoch;
         hold_left <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IdlePercent);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ring_board.check_status(rsp_tdata);
   end

   task send_event(input logic [KindWidth-1:0] kind, input logic [ByteWidth-1:0] data);
      while (!quiet && $urandom_range(0, 99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ring_board.note_event(kind, data);
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ring_board.expected_status.size() != 0) @(posedge clock);
   endtask

   function logic [ByteWidth-1:0] pick_byte(int cr_percent);
      return ($urandom_range(0, 99) < cr_percent) ? CrByte : ByteWidth'($urandom_range(0, 255));
   endfunction

   task send_random_event();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) send_event(KIND_RX, pick_byte(12));
      else if (roll < 45) send_event(KIND_TX_READY, pick_byte(0));
      else if (roll < 65) send_event(KIND_PUT, pick_byte(0));
      else if (roll < 88) send_event(KIND_GET, pick_byte(0));
      else if (roll < 94) send_event(KIND_LINE_ACK, pick_byte(0));
      else send_event(KindWidth'($urandom_range(KindUnusedLo, KindUnusedHi)), pick_byte(0));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty rings, transmitter off, ignored kinds
      send_event(KIND_GET, 8'hFF);
      send_event(KIND_TX_READY, 8'h00);
      send_event(KindUnusedLo, 8'h5A);
      send_event(KindUnusedHi, 8'hA5);
      send_event(KIND_LINE_ACK, 8'h00);
      // receive extremes and a carriage return, then read them back
      send_event(KIND_RX, 8'h00);
      send_event(KIND_RX, 8'hFF);
      send_event(KIND_RX, CrByte);
      send_event(KIND_GET, 8'h00);
      send_event(KIND_GET, 8'h00);
      send_event(KIND_GET, 8'h00);
      send_event(KIND_GET, 8'h00);
      // put while idle sends at once, later puts queue
      send_event(KIND_PUT, 8'hA5);
      send_event(KIND_PUT, 8'h00);
      send_event(KIND_PUT, 8'hFF);
      send_event(KIND_TX_READY, 8'h00);
      send_event(KIND_TX_READY, 8'h00);
      send_event(KIND_TX_READY, 8'h00);
      send_event(KindUnusedMid, 8'h0D);
      send_event(KIND_LINE_ACK, 8'hFF);
      wait_drained();

      // fill the receive ring with carriage returns past full, then swap
      // one byte out for one carriage return in until the line count
      // saturates; hold off the receiver early, then run without idling
      for (int i = 0; i < Depth + 2; i++) send_event(KIND_RX, CrByte);
      for (int i = 0; i < Depth; i++) begin
         if (i == 20) hold_epoch <= hold_epoch + 1;
         if (i == 60) quiet <= 1'b1;
         if (i == 80) wait_drained();
         if (i == 110) quiet <= 1'b0;
         send_event(KIND_GET, pick_byte(0));
         send_event(KIND_RX, CrByte);
      end
      wait_drained();

      // fill the transmit ring past full while busy
      send_event(KIND_TX_READY, pick_byte(0));
      for (int i = 0; i < Depth + 3; i++) send_event(KIND_PUT, pick_byte(0));
      wait_drained();

      for (int i = 0; i < 20; i++) send_random_event();

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ring_board.expected_status.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (ring_board.mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ubq_pkg.sv
rtl/ubq_ring.sv
rtl/uart_buffered_rx_tx_queues.sv
test/uart_buffered_rx_tx_queues_test.sv
